// File: hdl/checksummed_frame_receiver_core_defines.svh
// Assertion helpers shared by the frame receiver RTL.
`ifndef CHECKSUMMED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define CHECKSUMMED_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CFR_ASSERT_SAME(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
    else $error("frame receiver check failed");

// Next-cycle implication, checked outside reset.
`define CFR_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
    else $error("frame receiver check failed");

`endif

// File: hdl/cfr_pkg.sv
package cfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgAddrW = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteW-1:0]  HdrByte = 8'hFF;
  localparam logic [ByteW-1:0]  ChkMask = 8'hFE;
  localparam logic [ByteW-1:0]  MinLen  = 8'd7;

  localparam logic [ByteW-1:0]  MaxLenRst  = 8'd255;
  localparam logic [TicksW-1:0] TimeoutRst = 16'd1000;

  // Byte positions with a special meaning.
  localparam logic [ByteW-1:0] PosHunt  = 8'd0;
  localparam logic [ByteW-1:0] PosHdr2  = 8'd1;
  localparam logic [ByteW-1:0] PosLen   = 8'd2;
  localparam logic [ByteW-1:0] PosBody  = 8'd3;
  localparam logic [ByteW-1:0] PosChk1  = 8'd5;
  localparam logic [ByteW-1:0] PosChk2  = 8'd6;

  typedef enum logic [CfgAddrW-1:0] {
    RegMaxFrameLen = 8'd0,
    RegTimeoutTicks = 8'd1
  } cfg_reg_e;

  typedef enum logic [StatusW-1:0] {
    StBusy    = 3'd0,
    StOk      = 3'd1,
    StBadSum  = 3'd2,
    StTooLong = 3'd3,
    StBadLen  = 3'd4,
    StTimeout = 3'd5
  } status_e;

endpackage

// File: hdl/cfr_intf.sv
interface cfr_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [cfr_pkg::ByteW-1:0]      rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface cfr_out_if;
  logic                           valid;
  logic                           ready;
  logic [cfr_pkg::ByteW-1:0]      data_byte;
  logic [cfr_pkg::ByteW-1:0]      byte_index;
  logic                           frame_end;
  logic [cfr_pkg::StatusW-1:0]    frame_status;

  modport source (output valid, output data_byte, output byte_index, output frame_end,
                  output frame_status, input ready);
  modport sink (input valid, input data_byte, input byte_index, input frame_end,
                input frame_status, output ready);
endinterface

interface cfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cfr_pkg::CfgAddrW-1:0]   addr;
  logic [cfr_pkg::CfgDataW-1:0]   wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

// File: hdl/checksummed_frame_receiver_core.sv
// Latency: a result is valid in the cycle after the request that caused it is accepted.
// Throughput: one request (byte or tick) per clock, sustained, because all frame work
// is a single XOR, compare and increment between the state registers and the result register.
// The input stalls only while a registered result waits to be taken downstream.
// Reset (rst_ni low, asynchronous): frame state cleared to hunting, limits back to 255 and 1000.
`include "checksummed_frame_receiver_core_defines.svh"

module checksummed_frame_receiver_core (
  input  logic clk_i,
  input  logic rst_ni,
  cfr_in_if.sink   in_chan,
  cfr_out_if.source out_chan,
  cfr_cfg_if.sink  cfg_chan
);

  localparam int unsigned BW = cfr_pkg::ByteW;
  localparam int unsigned TW = cfr_pkg::TicksW;

  // Limits.
  logic [BW-1:0] max_len_q;
  logic [TW-1:0] timeout_q;

  // Frame state.
  logic [BW-1:0] pos_q, pos_d;
  logic [BW-1:0] len_q, len_d;
  logic [BW-1:0] xor_q, xor_d;
  logic [BW-1:0] chk1_q, chk1_d;
  logic [BW-1:0] chk2_q, chk2_d;
  logic [TW-1:0] ticks_q, ticks_d;

  // Result register.
  logic                out_valid_q, out_valid_d;
  logic [BW-1:0]       out_data_q, out_data_d;
  logic [BW-1:0]       out_idx_q, out_idx_d;
  logic                out_end_q, out_end_d;
  cfr_pkg::status_e    out_status_q, out_status_d;

  logic                in_fire;
  logic                res_valid;
  logic [TW-1:0]       ticks_inc;
  logic [BW-1:0]       xor_body;
  logic [BW-1:0]       c1;
  logic [BW-1:0]       c2;
  logic                last_byte;

  assign in_chan.ready  = !out_valid_q || out_chan.ready;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign ticks_inc = (ticks_q != '1) ? ticks_q + TW'(1) : ticks_q;
  // The check bytes themselves stay out of the running XOR.
  assign xor_body  = (pos_q == cfr_pkg::PosChk1 || pos_q == cfr_pkg::PosChk2) ? xor_q
                                                                              : xor_q ^ in_chan.rx_byte;
  assign c1        = xor_body & cfr_pkg::ChkMask;
  assign c2        = ~c1 & cfr_pkg::ChkMask;
  assign last_byte = ({1'b0, pos_q} + (BW+1)'(1)) >= {1'b0, len_q};

  always_comb begin
    pos_d        = pos_q;
    len_d        = len_q;
    xor_d        = xor_q;
    chk1_d       = chk1_q;
    chk2_d       = chk2_q;
    ticks_d      = ticks_q;
    res_valid    = 1'b0;
    out_data_d   = in_chan.rx_byte;
    out_idx_d    = pos_q;
    out_end_d    = 1'b0;
    out_status_d = cfr_pkg::StBusy;

    if (in_fire) begin
      if (in_chan.command) begin
        // Ticks count only once a header has started.
        if (pos_q != cfr_pkg::PosHunt) begin
          if (ticks_inc >= timeout_q) begin
            res_valid    = 1'b1;
            out_data_d   = '0;
            out_end_d    = 1'b1;
            out_status_d = cfr_pkg::StTimeout;
            pos_d        = cfr_pkg::PosHunt;
            ticks_d      = '0;
          end else begin
            ticks_d = ticks_inc;
          end
        end
      end else if (pos_q == cfr_pkg::PosHunt) begin
        if (in_chan.rx_byte == cfr_pkg::HdrByte) begin
          pos_d   = cfr_pkg::PosHdr2;
          ticks_d = '0;
        end
      end else if (pos_q == cfr_pkg::PosHdr2) begin
        if (in_chan.rx_byte == cfr_pkg::HdrByte) begin
          pos_d = cfr_pkg::PosLen;
        end else begin
          pos_d   = cfr_pkg::PosHunt;
          ticks_d = '0;
        end
      end else if (pos_q == cfr_pkg::PosLen) begin
        res_valid = 1'b1;
        if (in_chan.rx_byte > max_len_q) begin
          out_end_d    = 1'b1;
          out_status_d = cfr_pkg::StTooLong;
          pos_d        = cfr_pkg::PosHunt;
          ticks_d      = '0;
        end else if (in_chan.rx_byte < cfr_pkg::MinLen) begin
          out_end_d    = 1'b1;
          out_status_d = cfr_pkg::StBadLen;
          pos_d        = cfr_pkg::PosHunt;
          ticks_d      = '0;
        end else begin
          len_d = in_chan.rx_byte;
          xor_d = in_chan.rx_byte;
          pos_d = cfr_pkg::PosBody;
        end
      end else begin
        res_valid = 1'b1;
        xor_d     = xor_body;
        if (pos_q == cfr_pkg::PosChk1) begin
          chk1_d = in_chan.rx_byte;
        end else if (pos_q == cfr_pkg::PosChk2) begin
          chk2_d = in_chan.rx_byte;
        end
        if (last_byte) begin
          // The checks use this byte's contribution as well.
          out_end_d    = 1'b1;
          out_status_d = (chk1_d == c1 && chk2_d == c2) ? cfr_pkg::StOk
                                                       : cfr_pkg::StBadSum;
          pos_d        = cfr_pkg::PosHunt;
          ticks_d      = '0;
        end else begin
          pos_d = pos_q + BW'(1);
        end
      end
    end

    if (in_fire) begin
      out_valid_d = res_valid;
    end else if (out_chan.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= cfr_pkg::MaxLenRst;
      timeout_q <= cfr_pkg::TimeoutRst;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.addr)
        cfr_pkg::RegMaxFrameLen:  max_len_q <= cfg_chan.wdata[BW-1:0];
        cfr_pkg::RegTimeoutTicks: timeout_q <= cfg_chan.wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= cfr_pkg::PosHunt;
      len_q       <= '0;
      xor_q       <= '0;
      chk1_q      <= '0;
      chk2_q      <= '0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      len_q       <= len_d;
      xor_q       <= xor_d;
      chk1_q      <= chk1_d;
      chk2_q      <= chk2_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q   <= out_data_d;
      out_idx_q    <= out_idx_d;
      out_end_q    <= out_end_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_chan.valid        = out_valid_q;
  assign out_chan.data_byte    = out_data_q;
  assign out_chan.byte_index   = out_idx_q;
  assign out_chan.frame_end    = out_end_q;
  assign out_chan.frame_status = out_status_q;

  // Only the final result of a frame carries a verdict.
  `CFR_ASSERT_SAME(a_end_has_status, clk_i, rst_ni, out_valid_q,
                   out_end_q == (out_status_q != cfr_pkg::StBusy))
  // A final result always sends the block back to hunting.
  `CFR_ASSERT_NEXT(a_end_rehunts, clk_i, rst_ni, in_fire && res_valid && out_end_d,
                   pos_q == cfr_pkg::PosHunt && ticks_q == '0)
  // An in-progress result leaves the block inside the frame body.
  `CFR_ASSERT_SAME(a_busy_in_body, clk_i, rst_ni, out_valid_q && !out_end_q,
                   pos_q >= cfr_pkg::PosBody)

endmodule
